// File: rtl/magic_header_frame_deframer_defines.svh
// Assertion macros used by the deframer core RTL.
`ifndef MAGIC_HEADER_FRAME_DEFRAMER_DEFINES_SVH
`define MAGIC_HEADER_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MHFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MHFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mhfd_pkg.sv
// Types, constants and helpers for the magic-header frame deframer.
`default_nettype none

package mhfd_pkg;

	// Frame layout.
	localparam int unsigned COUNT_W          = 9;
	localparam int unsigned MAGIC_LEN        = 6;
	localparam int unsigned HEADER_LEN       = 9;
	localparam int unsigned POS_VERSION      = 6;
	localparam int unsigned POS_TYPE         = 7;
	localparam int unsigned MAX_FRAME_BYTES_DEF = 128;
	localparam logic [7:0]  FRAME_VERSION_OK = 8'h01;

	// Magic letters "IMPROV".
	localparam logic [7:0] MAGIC_I = 8'h49;
	localparam logic [7:0] MAGIC_M = 8'h4D;
	localparam logic [7:0] MAGIC_P = 8'h50;
	localparam logic [7:0] MAGIC_R = 8'h52;
	localparam logic [7:0] MAGIC_O = 8'h4F;
	localparam logic [7:0] MAGIC_V = 8'h56;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2,
		KIND_ABANDON = 2'd3
	} kind_t;

	// One result beat.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] packet_type;
		logic [7:0] payload_length;
	} result_t;

	// Expected magic letter at a given match position.
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = MAGIC_I;
			3'd1:    c = MAGIC_M;
			3'd2:    c = MAGIC_P;
			3'd3:    c = MAGIC_R;
			3'd4:    c = MAGIC_O;
			3'd5:    c = MAGIC_V;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mhfd_core.sv
// Frame state and per-byte parsing logic of the deframer.
`default_nettype none

`include "magic_header_frame_deframer_defines.svh"

module mhfd_core
	import mhfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	output result_t         res
);

	localparam logic [COUNT_W-1:0] MAX_CNT   = COUNT_W'(MAX_FRAME_BYTES);
	localparam logic [COUNT_W-1:0] MAGIC_CNT = COUNT_W'(MAGIC_LEN);
	localparam logic [COUNT_W-1:0] HDR_CNT   = COUNT_W'(HEADER_LEN);
	localparam logic [COUNT_W-1:0] VER_POS   = COUNT_W'(POS_VERSION);
	localparam logic [COUNT_W-1:0] TYPE_POS  = COUNT_W'(POS_TYPE);

	logic [COUNT_W-1:0] count_q, count_d;
	logic [7:0]         sum_q, sum_d;
	logic [7:0]         ver_q, ver_d;
	logic [7:0]         type_q, type_d;
	logic [7:0]         len_q, len_d;
	logic               hunting;
	logic [COUNT_W:0]   payload_end;
	logic [7:0]         sum_plus;
	logic [COUNT_W-1:0] count_inc;

	assign hunting     = count_q < MAGIC_CNT;
	assign payload_end = {1'b0, HDR_CNT} + {{(COUNT_W - 7){1'b0}}, len_q};
	assign sum_plus    = sum_q + rx_byte;
	assign count_inc   = count_q + COUNT_W'(1);

	// Next frame state and the result for the byte in flight.
	always_comb begin
		count_d   = count_q;
		sum_d     = sum_q;
		ver_d     = ver_q;
		type_d    = type_q;
		len_d     = len_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_PAYLOAD, data_byte: 8'h00, byte_index: 8'h00,
			packet_type: type_q, payload_length: len_q};
		if (step) begin
			if (hunting) begin
				// Magic hunt; an 'I' that breaks the match starts a new one.
				if (rx_byte == magic_char(count_q[2:0])) begin
					count_d = count_inc;
					sum_d   = sum_plus;
				end else if (rx_byte == MAGIC_I) begin
					count_d = COUNT_W'(1);
					sum_d   = rx_byte;
				end else begin
					count_d = '0;
					sum_d   = 8'h00;
				end
			end else if (count_q >= MAX_CNT) begin
				// Frame overran the limit: drop this byte and resume hunting.
				count_d   = '0;
				sum_d     = 8'h00;
				res_valid = 1'b1;
				res.kind  = KIND_ABANDON;
			end else if (count_q < HDR_CNT) begin
				// Version, type and length bytes.
				count_d = count_inc;
				sum_d   = sum_plus;
				if (count_q == VER_POS) begin
					ver_d = rx_byte;
				end else if (count_q == TYPE_POS) begin
					type_d = rx_byte;
				end else begin
					len_d = rx_byte;
				end
			end else if ({1'b0, count_q} < payload_end) begin
				// Payload byte, passed on as it arrives.
				count_d        = count_inc;
				sum_d          = sum_plus;
				res_valid      = 1'b1;
				res.kind       = KIND_PAYLOAD;
				res.data_byte  = rx_byte;
				res.byte_index = 8'(count_q - HDR_CNT);
			end else begin
				// Checksum byte closes the frame.
				count_d   = '0;
				sum_d     = 8'h00;
				res_valid = 1'b1;
				res.kind  = ((sum_q == rx_byte) && (ver_q == FRAME_VERSION_OK)) ?
					KIND_GOOD : KIND_BAD;
			end
		end
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= 8'h00;
			ver_q   <= 8'h00;
			type_q  <= 8'h00;
			len_q   <= 8'h00;
		end else begin
			count_q <= count_d;
			sum_q   <= sum_d;
			ver_q   <= ver_d;
			type_q  <= type_d;
			len_q   <= len_d;
		end
	end

	`MHFD_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= MAX_CNT, "byte count past limit")
	`MHFD_ASSERT_IMPL(a_hunt_silent, clk, arst_n, hunting, !res_valid, "result during magic hunt")
	`MHFD_ASSERT_NEXT(a_end_restart, clk, arst_n, res_valid && (res.kind != KIND_PAYLOAD), count_q == '0, "no restart after frame end")

endmodule

`default_nettype wire

// File: rtl/mhfd_out_reg.sv
// Result register of the deframer output channel.
`default_nettype none

module mhfd_out_reg
	import mhfd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t load_data,
	input  wire logic    result_stall,
	output logic         result_valid,
	output result_t      result,
	output logic         free
);

	logic    valid_q;
	result_t data_q;

	// The register can take a new beat when empty or when its beat leaves now.
	assign free         = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/magic_header_frame_deframer.sv
// Top level of the magic-header frame deframer.
// Usage:
//   Input channel: one received serial byte per beat on rx_byte, with
//   byte_valid and byte_stall. Output channel: result beats on kind,
//   data_byte, byte_index, packet_type and payload_length, with
//   result_valid and result_stall.
//   A frame is "IMPROV", version, type, length, payload and an 8-bit
//   additive checksum. Payload bytes come out as they arrive (kind 0);
//   the checksum byte yields a good (1) or bad (2) end beat, and a frame
//   that grows past MAX_FRAME_BYTES yields an abandon beat (3).
//   Magic and header bytes give no result beat.
//   Path: an accepted byte waits in the input register, is parsed
//   combinationally and its result is loaded into the result register.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   single input register and the combinational parse before the result register.
//   Reset (arst_n low) clears the frame state and empties both registers;
//   the parser then hunts for the magic.
//   When the receiver stalls with a result held, the input register keeps
//   its byte and byte_stall rises until the result register frees up.
`default_nettype none

module magic_header_frame_deframer
	import mhfd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] rx_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      kind,
	output logic [7:0]      data_byte,
	output logic [7:0]      byte_index,
	output logic [7:0]      packet_type,
	output logic [7:0]      payload_length
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       free;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    result;

	// Input register: refilled whenever its byte moves on or it is empty.
	assign step       = valid_s1 && free;
	assign byte_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	mhfd_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (byte_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	mhfd_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (res_valid),
		.load_data   (res),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result      (result),
		.free        (free)
	);

	// Result fields onto the output ports.
	assign kind           = result.kind;
	assign data_byte      = result.data_byte;
	assign byte_index     = result.byte_index;
	assign packet_type    = result.packet_type;
	assign payload_length = result.payload_length;

endmodule

`default_nettype wire
